[rtl/dual_stack_shared_array_macros.svh]
// Assertion macros shared by the checker files of the dual stack block.
`ifndef DUAL_STACK_SHARED_ARRAY_MACROS_SVH
`define DUAL_STACK_SHARED_ARRAY_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DSSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dual stack check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define DSSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dual stack check failed: next-cycle implication");

`endif

[rtl/dssa_pkg.sv]
// Package: sizes, codes and beat types of the dual stack block.
`timescale 1ns / 1ps
package dssa_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int FIELD_W   = 32;
  localparam int CNT_OUT_W = 5;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_POP   = 2'd2;

  typedef struct packed {
    logic [1:0]                op;
    logic                      which_stack;
    logic signed [FIELD_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic                      accepted;
    logic signed [FIELD_W-1:0] top_low;
    logic signed [FIELD_W-1:0] top_high;
    logic                      empty_low;
    logic                      empty_high;
    logic [CNT_OUT_W-1:0]      count_low;
    logic [CNT_OUT_W-1:0]      count_high;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr_low;
    logic [ADDR_W-1:0]    raddr_high;
  } ram_req_t;

  typedef struct packed {
    logic             out_valid;
    logic             accepted;
    logic [CNT_W-1:0] low_count;
    logic [CNT_W-1:0] high_count;
  } ctrl_stat_t;

endpackage

[rtl/dssa_ram.sv]
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module dssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[rtl/dssa_ctrl.sv]
// Control: stack counts, push/pop decision, store write and read sequencing.
`timescale 1ns / 1ps
module dssa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dssa_pkg::in_item_t   in_data,
  output dssa_pkg::ram_req_t   ram_req,
  output dssa_pkg::ctrl_stat_t stat
);

  localparam int AW = dssa_pkg::ADDR_W;
  localparam int CW = dssa_pkg::CNT_W;
  localparam int WB = dssa_pkg::WORD_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(dssa_pkg::DEPTH - 1);
  localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(dssa_pkg::DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(dssa_pkg::DEPTH);

  dssa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    low_r, low_nxt;
  logic [CW-1:0]    high_r, high_nxt;
  logic             acc_r, acc_nxt;
  logic             take;
  logic             room;
  logic [CW:0]      used;
  logic [CW-1:0]    low_top;
  logic [CW-1:0]    high_top;

  assign take = start && !busy;
  assign used = {1'b0, low_r} + {1'b0, high_r};
  assign room = used < DEPTH_EXT;

  // Top entries of both stacks; only used when the stack is not empty.
  assign low_top  = low_r - 1'b1;
  assign high_top = DEPTH_CNT - high_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dssa_pkg::ST_IDLE: if (take) state_nxt = dssa_pkg::ST_READ;
      dssa_pkg::ST_READ: state_nxt = dssa_pkg::ST_OUT;
      dssa_pkg::ST_OUT:  state_nxt = take ? dssa_pkg::ST_READ : dssa_pkg::ST_IDLE;
      default:           state_nxt = dssa_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    busy            = 1'b0;
    stat.out_valid  = 1'b0;
    stat.accepted   = acc_r;
    stat.low_count  = low_r;
    stat.high_count = high_r;
    unique case (state_r)
      dssa_pkg::ST_IDLE: ;
      dssa_pkg::ST_READ: busy = 1'b1;
      dssa_pkg::ST_OUT:  stat.out_valid = 1'b1;
      default:           ;
    endcase
  end

  // Decide the operation and update counts on the accept edge.
  always_comb begin
    low_nxt            = low_r;
    high_nxt           = high_r;
    acc_nxt            = acc_r;
    ram_req.we         = 1'b0;
    ram_req.waddr      = low_r[AW-1:0];
    ram_req.wdata      = WB'(unsigned'(in_data.push_value));
    ram_req.raddr_low  = low_top[AW-1:0];
    ram_req.raddr_high = high_top[AW-1:0];
    if (take) begin
      acc_nxt = 1'b0;
      unique case (in_data.op)
        dssa_pkg::OP_QUERY: acc_nxt = 1'b1;
        dssa_pkg::OP_PUSH: begin
          if (room) begin
            acc_nxt    = 1'b1;
            ram_req.we = 1'b1;
            if (!in_data.which_stack) begin
              ram_req.waddr = low_r[AW-1:0];
              low_nxt       = low_r + 1'b1;
            end else begin
              ram_req.waddr = LAST_ADDR - high_r[AW-1:0];
              high_nxt      = high_r + 1'b1;
            end
          end
        end
        dssa_pkg::OP_POP: begin
          if (!in_data.which_stack) begin
            if (low_r != '0) begin
              acc_nxt = 1'b1;
              low_nxt = low_r - 1'b1;
            end
          end else begin
            if (high_r != '0) begin
              acc_nxt  = 1'b1;
              high_nxt = high_r - 1'b1;
            end
          end
        end
        default: acc_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dssa_pkg::ST_IDLE;
      low_r   <= '0;
      high_r  <= '0;
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

[rtl/dual_stack_shared_array.sv]
// Top level: two stacks growing toward each other in one shared store.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive in_data (op, which_stack, push_value) and raise
//   start; the beat is taken at a rising edge where start is high and
//   busy is low. op is query, push or pop, aimed at the low-end stack
//   (grows up from entry 0) or the high-end stack (grows down from the
//   last entry).
//   Result channel: out_valid is high for exactly one cycle per item and
//   out_data carries the accepted flag, both top words (-1 when empty),
//   both empty flags and both counts as they stand after the item.
//   After the accept edge the sequencer passes through a busy read state
//   and then a result state, where the beat sits on the ports. A new item
//   may be taken in the cycle its predecessor's result is shown, but not
//   while busy. The pacing is set by the store's registered read: the
//   write of a push lands on the accept edge, the two top entries are
//   read in the busy state and their data comes out in the result state.
//   The receiver cannot stall: a result beat is gone after its cycle.
//   Reset (rst_n low, synchronous) empties both stacks and idles the
//   sequencer; store contents are left as they are and never shown.
module dual_stack_shared_array (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dssa_pkg::in_item_t  in_data,
  output logic                out_valid,
  output dssa_pkg::out_item_t out_data
);

  localparam int FW  = dssa_pkg::FIELD_W;
  localparam int COW = dssa_pkg::CNT_OUT_W;
  localparam int WB  = dssa_pkg::WORD_BITS;

  dssa_pkg::ram_req_t   ram_req;
  dssa_pkg::ctrl_stat_t stat;
  logic [WB-1:0]        rdata_low;
  logic [WB-1:0]        rdata_high;
  logic                 low_empty;
  logic                 high_empty;

  // Counts, decision and store sequencing.
  dssa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .ram_req (ram_req),
    .stat    (stat)
  );

  // Shared store: one write port, one read port per stack top.
  dssa_ram #(
    .WIDTH (WB),
    .DEPTH (dssa_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_low),
    .raddr_b (ram_req.raddr_high),
    .rdata_a (rdata_low),
    .rdata_b (rdata_high)
  );

  assign low_empty  = (stat.low_count == '0);
  assign high_empty = (stat.high_count == '0);

  // Assemble the result beat; an empty stack shows all ones instead of
  // whatever its stale entry holds.
  assign out_valid           = stat.out_valid;
  assign out_data.accepted   = stat.accepted;
  assign out_data.top_low    = low_empty  ? '1 : FW'(signed'(rdata_low));
  assign out_data.top_high   = high_empty ? '1 : FW'(signed'(rdata_high));
  assign out_data.empty_low  = low_empty;
  assign out_data.empty_high = high_empty;
  assign out_data.count_low  = COW'(stat.low_count);
  assign out_data.count_high = COW'(stat.high_count);

endmodule

[rtl/dssa_chk.sv]
// Checker: port-level properties of the dual stack block, bound to the top.
`timescale 1ns / 1ps
`include "dual_stack_shared_array_macros.svh"
module dssa_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input dssa_pkg::in_item_t  in_data,
  input logic                out_valid,
  input dssa_pkg::out_item_t out_data
);

  localparam logic [dssa_pkg::CNT_OUT_W:0] DEPTH_X = (dssa_pkg::CNT_OUT_W + 1)'(dssa_pkg::DEPTH);

  // An accepted beat always raises busy, and busy always leads to a result with busy low.
  `DSSA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `DSSA_ASSERT_NXT(a_busy_result, clk, rst_n, busy, out_valid && !busy)
  // Results never come back to back.
  `DSSA_ASSERT_NXT(a_no_b2b, clk, rst_n, out_valid, !out_valid)
  // An empty low stack shows a zero count and an all-ones top.
  `DSSA_ASSERT_IMP(a_empty_low, clk, rst_n, out_valid && out_data.empty_low, out_data.count_low == '0 && out_data.top_low == '1)
  // The two stacks never hold more than the store.
  `DSSA_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, ({1'b0, out_data.count_low} + {1'b0, out_data.count_high}) <= DEPTH_X)

endmodule

bind dual_stack_shared_array dssa_chk u_dssa_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[tb/dssa_stack_checker.sv]
`timescale 1ns / 1ps
// Checker: mirrors both stacks, predicts every result beat and compares it.
module dssa_stack_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  dssa_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  dssa_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  awaiting,
  output int                  results_seen,
  output int                  refused_seen
);
  import dssa_pkg::*;

  localparam logic signed [FIELD_W-1:0] EMPTY_TOP = -1;

  logic [WORD_BITS-1:0] store_words [DEPTH];
  int unsigned          low_depth = 0;
  int unsigned          high_depth = 0;
  out_item_t            outcome_q [$];
  int                   fail_count = 0;
  int                   backlog = 0;
  int                   result_count = 0;
  int                   refused_count = 0;

  assign mismatches   = fail_count;
  assign awaiting     = backlog;
  assign results_seen = result_count;
  assign refused_seen = refused_count;

  // Apply one command to the mirrored stacks and return the beat it should produce.
  function automatic out_item_t apply_stack_op(input in_item_t item);
    out_item_t res;
    logic      room;
    res  = '0;
    room = (low_depth + high_depth) < DEPTH;
    case (item.op)
      OP_QUERY: begin
        res.accepted = 1'b1;
      end
      OP_PUSH: begin
        if (room) begin
          if (item.which_stack) begin
            store_words[DEPTH - 1 - high_depth] = item.push_value[WORD_BITS-1:0];
            high_depth++;
          end else begin
            store_words[low_depth] = item.push_value[WORD_BITS-1:0];
            low_depth++;
          end
          res.accepted = 1'b1;
        end
      end
      OP_POP: begin
        if (item.which_stack) begin
          if (high_depth > 0) begin
            high_depth--;
            res.accepted = 1'b1;
          end
        end else if (low_depth > 0) begin
          low_depth--;
          res.accepted = 1'b1;
        end
      end
      default: begin
        res.accepted = 1'b0;
      end
    endcase
    if (low_depth > 0) res.top_low = $signed(store_words[low_depth - 1]);
    else res.top_low = EMPTY_TOP;
    if (high_depth > 0) res.top_high = $signed(store_words[DEPTH - high_depth]);
    else res.top_high = EMPTY_TOP;
    res.empty_low  = (low_depth == 0);
    res.empty_high = (high_depth == 0);
    res.count_low  = CNT_OUT_W'(low_depth);
    res.count_high = CNT_OUT_W'(high_depth);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      low_depth  = 0;
      high_depth = 0;
      outcome_q.delete();
      backlog <= 0;
    end else begin
      // Check the result first; a beat accepted on this edge cannot show yet.
      if (out_valid) begin
        result_count++;
        if (outcome_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, got %0h", $time, out_data);
        end else begin
          want = outcome_q.pop_front();
          if (!want.accepted) refused_count++;
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("top_low", want.top_low, out_data.top_low);
          check_field("top_high", want.top_high, out_data.top_high);
          check_field("empty_low", want.empty_low, out_data.empty_low);
          check_field("empty_high", want.empty_high, out_data.empty_high);
          check_field("count_low", want.count_low, out_data.count_low);
          check_field("count_high", want.count_high, out_data.count_high);
        end
      end
      if (start && !busy) outcome_q.push_back(apply_stack_op(in_data));
      backlog <= outcome_q.size();
    end
  end

endmodule

[tb/tb_dual_stack_shared_array.sv]
`timescale 1ns / 1ps
// Testbench top: drives command beats into the dual stack and gives the verdict.
module tb_dual_stack_shared_array;
  import dssa_pkg::*;

  // The fourth op code does nothing but must be reported as not accepted.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic       STACK_LOW   = 1'b0;
  localparam logic       STACK_HIGH  = 1'b1;
  // Slowest run is roughly 1700 beats; allow far more.
  localparam int         CYCLE_LIMIT = 200000;
  // Tail watched after the drain to catch stray result beats.
  localparam int         TAIL_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  int mismatches;
  int awaiting;
  int results_seen;
  int refused_seen;
  int beats_sent = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  dual_stack_shared_array uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  dssa_stack_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .results_seen (results_seen),
    .refused_seen (refused_seen)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dual_stack_shared_array regression: fail");
      $finish;
    end
  end

  // Favor the sign and magnitude extremes; the rest is uniform over all 32 bits.
  function automatic logic [FIELD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Send one command beat. Idle first with the given odds per cycle, then hold
  // start until the block takes the beat (start high, busy low at the edge).
  task automatic send_beat(input logic [1:0] op, input logic which,
                           input logic [FIELD_W-1:0] value, input int gap_pct);
    in_item_t item;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    item.op          = op;
    item.which_stack = which;
    item.push_value  = value;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // Drop start and hold off until every predicted result has been checked.
  // The first edge lets the checker's backlog catch up with the last accept.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Random traffic in bursts: fills that run past full, drains that run past
  // empty on both sides, mixed traffic, and some noise with the unused op code.
  task automatic run_phase(input int n_beats, input int gap_pct);
    int         sent;
    int         kind;
    int         len;
    logic       side;
    logic [1:0] op;
    sent = 0;
    while (sent < n_beats) begin
      kind = $urandom_range(9);
      side = 1'($urandom_range(1));
      if (kind < 3) len = $urandom_range(17, 20);
      else if (kind < 6) len = 34;
      else len = $urandom_range(4, 12);
      for (int k = 0; k < len; k++) begin
        if (kind == 0) begin
          // One stack alone takes all the room that is left in the store.
          send_beat(OP_PUSH, side, pick_word(), gap_pct);
        end else if (kind < 3) begin
          send_beat(OP_PUSH, 1'($urandom_range(1)), pick_word(), gap_pct);
        end else if (kind < 6) begin
          // Empty one side, then the other, with refused pops at each bottom.
          send_beat(OP_POP, (k < 17) ? side : ~side, pick_word(), gap_pct);
        end else if (kind < 9) begin
          case ($urandom_range(3))
            0: op = OP_QUERY;
            1, 2: op = OP_PUSH;
            default: op = OP_POP;
          endcase
          send_beat(op, 1'($urandom_range(1)), pick_word(), gap_pct);
        end else begin
          op = 2'($urandom_range(3));
          send_beat(op, 1'($urandom_range(1)), $urandom(), gap_pct);
        end
      end
      sent += len;
    end
  endtask

  initial begin
    // Hold reset once, at the start, then release it.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: queries and pops on empty stacks, the unused op, extreme words
    // on both sides, then pops down past empty so both stacks end clear.
    send_beat(OP_QUERY, STACK_LOW, 32'h0, 0);
    send_beat(OP_POP, STACK_LOW, 32'h0, 0);
    send_beat(OP_POP, STACK_HIGH, 32'h0, 0);
    send_beat(OP_UNUSED, STACK_LOW, 32'hffff_ffff, 0);
    send_beat(OP_UNUSED, STACK_HIGH, 32'h0, 0);
    send_beat(OP_PUSH, STACK_LOW, 32'h7fff_ffff, 0);
    send_beat(OP_PUSH, STACK_HIGH, 32'h8000_0000, 0);
    send_beat(OP_QUERY, STACK_HIGH, 32'h1234_5678, 0);
    send_beat(OP_PUSH, STACK_LOW, 32'hffff_ffff, 0);
    send_beat(OP_PUSH, STACK_HIGH, 32'h0000_0000, 0);
    send_beat(OP_UNUSED, STACK_LOW, 32'h0, 0);
    send_beat(OP_POP, STACK_LOW, 32'h0, 0);
    send_beat(OP_POP, STACK_HIGH, 32'h0, 0);
    send_beat(OP_PUSH, STACK_HIGH, 32'h5555_5555, 0);
    send_beat(OP_PUSH, STACK_LOW, 32'haaaa_aaaa, 0);
    send_beat(OP_POP, STACK_LOW, 32'h0, 0);
    send_beat(OP_POP, STACK_LOW, 32'h0, 0);
    send_beat(OP_POP, STACK_LOW, 32'h0, 0);
    send_beat(OP_POP, STACK_HIGH, 32'h0, 0);
    send_beat(OP_POP, STACK_HIGH, 32'h0, 0);
    send_beat(OP_POP, STACK_HIGH, 32'h0, 0);
    send_beat(OP_QUERY, STACK_LOW, 32'h0, 0);

    // Pause until the block has caught up before each change of pacing.
    wait_drained();
    run_phase(600, 38);
    wait_drained();
    run_phase(600, 78);
    wait_drained();
    run_phase(500, 0);

    // Drain, then watch a few more cycles for stray result beats.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d command beats: directed, sparse, very sparse, back to back",
             beats_sent);
    $display("%0d result beats checked, %0d of them refused as full, empty or unused",
             results_seen, refused_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("dual_stack_shared_array regression: pass");
    end else begin
      $display("dual_stack_shared_array regression: fail");
    end
    $finish;
  end

endmodule
